/* hw/rtl/vidd_pkg.sv */
// Shared types and codes for the vertex index deduplication block.
`timescale 1ns / 1ps

package vidd_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_ZERO  = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_SATUR = 2'd3
    } status_t;

    // Control flags handed from one search cell to the next
    typedef struct packed {
        logic tok;      // search token present
        logic found;    // a cell upstream already matched
    } link_t;

endpackage

/* hw/rtl/vidd_cell.sv */
// One search cell: holds a table entry and passes the search result downstream.
`timescale 1ns / 1ps

module vidd_cell #(
    parameter int INDEX       = 0,
    parameter int TABLE_DEPTH = 256,
    parameter int REF_BITS    = 20,
    parameter int VERTEX_BITS = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // broadcast search key and fill count
    input  logic [REF_BITS-1:0]              key_pos,
    input  logic [REF_BITS-1:0]              key_tex,
    input  logic [REF_BITS-1:0]              key_nrm,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
    // broadcast write port
    input  logic                             wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   wr_idx,
    input  logic [VERTEX_BITS-1:0]           wr_vid,
    // chain link
    input  vidd_pkg::link_t                  in_link,
    input  logic [VERTEX_BITS-1:0]           in_vid,
    output vidd_pkg::link_t                  out_link,
    output logic [VERTEX_BITS-1:0]           out_vid
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    logic [REF_BITS-1:0]    pos_reg;
    logic [REF_BITS-1:0]    tex_reg;
    logic [REF_BITS-1:0]    nrm_reg;
    logic [VERTEX_BITS-1:0] vid_reg;

    vidd_pkg::link_t        link_reg;
    vidd_pkg::link_t        link_next;
    logic [VERTEX_BITS-1:0] ovid_reg;
    logic [VERTEX_BITS-1:0] ovid_next;
    logic                   hit;

    // entry is live only below the fill count
    assign hit = in_link.tok && !in_link.found && (count > CW'(INDEX)) &&
                 (pos_reg == key_pos) && (tex_reg == key_tex) && (nrm_reg == key_nrm);

    always_comb begin
        link_next.tok   = in_link.tok;
        link_next.found = in_link.found | hit;
        ovid_next       = hit ? vid_reg : in_vid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg <= '0;
        end else begin
            link_reg <= link_next;
        end
    end

    always_ff @(posedge aclk) begin
        ovid_reg <= ovid_next;
        if (wr_en && (wr_idx == IW'(INDEX))) begin
            pos_reg <= key_pos;
            tex_reg <= key_tex;
            nrm_reg <= key_nrm;
            vid_reg <= wr_vid;
        end
    end

    assign out_link = link_reg;
    assign out_vid  = ovid_reg;

endmodule

/* hw/rtl/vidd_ctrl.sv */
// Sequencer: takes corners and group starts, launches the search, decides the result and updates the table.
`timescale 1ns / 1ps

module vidd_ctrl #(
    parameter int TABLE_DEPTH = 256,
    parameter int REF_BITS    = 20,
    parameter int VERTEX_BITS = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input side, fields unpacked
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_func,
    input  logic [REF_BITS-1:0]              s_pos,
    input  logic [REF_BITS-1:0]              s_tex,
    input  logic [REF_BITS-1:0]              s_nrm,
    // result side, fields unpacked
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [VERTEX_BITS-1:0]           m_vid,
    output logic                             m_new,
    output logic [REF_BITS-1:0]              m_pos_slot,
    output logic [REF_BITS-1:0]              m_tex_slot,
    output logic [REF_BITS-1:0]              m_nrm_slot,
    output vidd_pkg::status_t                m_status,
    // to the cell row
    output logic [REF_BITS-1:0]              key_pos,
    output logic [REF_BITS-1:0]              key_tex,
    output logic [REF_BITS-1:0]              key_nrm,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] count,
    output logic                             wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]   wr_idx,
    output logic [VERTEX_BITS-1:0]           wr_vid,
    output vidd_pkg::link_t                  head_link,
    input  vidd_pkg::link_t                  tail_link,
    input  logic [VERTEX_BITS-1:0]           tail_vid
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_HOLD   = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [VERTEX_BITS-1:0] ctr_reg, ctr_next;
    logic                   tok_reg, tok_next;
    logic [REF_BITS-1:0]    kpos_reg, ktex_reg, knrm_reg;
    logic                   zero_reg;

    // result register and one pending slot behind it
    logic                   mval_reg, mval_next;
    logic                   pend_load, out_load_res, out_load_pend;
    logic [VERTEX_BITS-1:0] mvid_reg, pvid_reg;
    logic                   mnew_reg, pnew_reg;
    logic [REF_BITS-1:0]    mps_reg, mts_reg, mns_reg, pps_reg, pts_reg, pns_reg;
    vidd_pkg::status_t      mst_reg, pst_reg;

    // decided result
    logic [VERTEX_BITS-1:0] r_vid;
    logic                   r_new;
    logic [REF_BITS-1:0]    r_ps, r_ts, r_ns;
    vidd_pkg::status_t      r_st;
    logic                   take, done, out_free;

    assign take     = s_valid && s_ready;
    assign done     = (state_reg == S_SEARCH) && tail_link.tok;
    assign out_free = !mval_reg || m_ready;

    always_comb begin
        r_vid = '0;
        r_new = 1'b0;
        r_ps  = '0;
        r_ts  = '0;
        r_ns  = '0;
        r_st  = vidd_pkg::STAT_OK;
        wr_en = 1'b0;
        if (zero_reg) begin
            r_st = vidd_pkg::STAT_ZERO;
        end else if (tail_link.found) begin
            r_vid = tail_vid;
        end else if (count_reg == CW'(TABLE_DEPTH)) begin
            r_st = vidd_pkg::STAT_FULL;
        end else if (&ctr_reg) begin
            r_st = vidd_pkg::STAT_SATUR;
        end else begin
            r_vid = ctr_reg;
            r_new = 1'b1;
            r_ps  = kpos_reg - REF_BITS'(1);
            r_ts  = ktex_reg - REF_BITS'(1);
            r_ns  = knrm_reg - REF_BITS'(1);
            wr_en = done;
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ctr_next      = ctr_reg;
        tok_next      = 1'b0;
        mval_next     = mval_reg;
        pend_load     = 1'b0;
        out_load_res  = 1'b0;
        out_load_pend = 1'b0;
        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (take) begin
                    if (s_func) begin
                        count_next = '0;
                    end else begin
                        tok_next   = 1'b1;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (done) begin
                    if (wr_en) begin
                        count_next = count_reg + CW'(1);
                        ctr_next   = ctr_reg + VERTEX_BITS'(1);
                    end
                    if (out_free) begin
                        out_load_res = 1'b1;
                        mval_next    = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        pend_load  = 1'b1;
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (m_ready) begin
                    out_load_pend = 1'b1;
                    mval_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ctr_reg   <= '0;
            tok_reg   <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ctr_reg   <= ctr_next;
            tok_reg   <= tok_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && !s_func) begin
            kpos_reg <= s_pos;
            ktex_reg <= s_tex;
            knrm_reg <= s_nrm;
            zero_reg <= (s_pos == '0) || (s_tex == '0) || (s_nrm == '0);
        end
        if (pend_load) begin
            pvid_reg <= r_vid;
            pnew_reg <= r_new;
            pps_reg  <= r_ps;
            pts_reg  <= r_ts;
            pns_reg  <= r_ns;
            pst_reg  <= r_st;
        end
        if (out_load_res) begin
            mvid_reg <= r_vid;
            mnew_reg <= r_new;
            mps_reg  <= r_ps;
            mts_reg  <= r_ts;
            mns_reg  <= r_ns;
            mst_reg  <= r_st;
        end else if (out_load_pend) begin
            mvid_reg <= pvid_reg;
            mnew_reg <= pnew_reg;
            mps_reg  <= pps_reg;
            mts_reg  <= pts_reg;
            mns_reg  <= pns_reg;
            mst_reg  <= pst_reg;
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = mval_reg;
    assign m_vid           = mvid_reg;
    assign m_new           = mnew_reg;
    assign m_pos_slot      = mps_reg;
    assign m_tex_slot      = mts_reg;
    assign m_nrm_slot      = mns_reg;
    assign m_status        = mst_reg;
    assign key_pos         = kpos_reg;
    assign key_tex         = ktex_reg;
    assign key_nrm         = knrm_reg;
    assign count           = count_reg;
    assign wr_idx          = count_reg[IW-1:0];
    assign wr_vid          = ctr_reg;
    assign head_link.tok   = tok_reg;
    assign head_link.found = 1'b0;

    // token reaches the end of the row only while a search is running
    a_tail_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_link.tok |-> (state_reg == S_SEARCH))
        else $error("search token outside a search");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // held result only while the output register is occupied
    a_hold_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HOLD) |-> mval_reg)
        else $error("pending result with empty output register");

    // stored entries never carry a zero reference
    a_no_zero_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_link.tok && tail_link.found) |-> !zero_reg)
        else $error("match on a key with a zero reference");

endmodule

/* hw/rtl/vertex_index_dedup.sv */
// Top level: stream ports, search cell row and sequencer.
//
// Usage: face corners arrive on the s_axis channel, tuser[0] set marks a group
// start (seen table cleared, no result), otherwise tdata carries the one-based
// position, texture and normal references. Each corner gives one result on
// m_axis: vertex index, new flag, zero-based fetch slots and a status code.
// The table is a row of TABLE_DEPTH cells; a search token walks the row one
// cell per cycle; a corner's result is registered once the token leaves the
// last cell, and the input is ready again when that result enters the output
// register. A group start clears only the fill count; the running vertex
// counter keeps counting across groups.
// Reset clears the fill count, the vertex counter and all handshake state;
// table contents need no clearing since only entries below the fill count
// are compared. A stalled receiver holds the result in the output register;
// one further result parks in a pending slot and the input then waits.
`timescale 1ns / 1ps

module vertex_index_dedup #(
    parameter int TABLE_DEPTH = 256,
    parameter int REF_BITS    = 20,
    parameter int VERTEX_BITS = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // position_ref, texture_ref, normal_ref
    input  logic [((3*REF_BITS+7)/8)*8-1:0] s_axis_tdata,
    // func
    input  logic [0:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // vertex_index, position_slot, texture_slot, normal_slot
    output logic [((VERTEX_BITS+3*REF_BITS+7)/8)*8-1:0] m_axis_tdata,
    // is_new, status
    output logic [2:0] m_axis_tuser
);

    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int ODW = ((VERTEX_BITS + 3*REF_BITS + 7) / 8) * 8;

    logic [REF_BITS-1:0]    key_pos, key_tex, key_nrm;
    logic [CW-1:0]          count;
    logic                   wr_en;
    logic [IW-1:0]          wr_idx;
    logic [VERTEX_BITS-1:0] wr_vid;

    vidd_pkg::link_t        links [TABLE_DEPTH+1];
    logic [VERTEX_BITS-1:0] vids  [TABLE_DEPTH+1];

    logic [VERTEX_BITS-1:0] m_vid;
    logic                   m_new;
    logic [REF_BITS-1:0]    m_ps, m_ts, m_ns;
    vidd_pkg::status_t      m_status;

    assign vids[0] = '0;

    vidd_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .REF_BITS    (REF_BITS),
        .VERTEX_BITS (VERTEX_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_func     (s_axis_tuser[0]),
        .s_pos      (s_axis_tdata[REF_BITS-1:0]),
        .s_tex      (s_axis_tdata[2*REF_BITS-1:REF_BITS]),
        .s_nrm      (s_axis_tdata[3*REF_BITS-1:2*REF_BITS]),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_vid      (m_vid),
        .m_new      (m_new),
        .m_pos_slot (m_ps),
        .m_tex_slot (m_ts),
        .m_nrm_slot (m_ns),
        .m_status   (m_status),
        .key_pos    (key_pos),
        .key_tex    (key_tex),
        .key_nrm    (key_nrm),
        .count      (count),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .wr_vid     (wr_vid),
        .head_link  (links[0]),
        .tail_link  (links[TABLE_DEPTH]),
        .tail_vid   (vids[TABLE_DEPTH])
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        vidd_cell #(
            .INDEX       (i),
            .TABLE_DEPTH (TABLE_DEPTH),
            .REF_BITS    (REF_BITS),
            .VERTEX_BITS (VERTEX_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .key_pos  (key_pos),
            .key_tex  (key_tex),
            .key_nrm  (key_nrm),
            .count    (count),
            .wr_en    (wr_en),
            .wr_idx   (wr_idx),
            .wr_vid   (wr_vid),
            .in_link  (links[i]),
            .in_vid   (vids[i]),
            .out_link (links[i+1]),
            .out_vid  (vids[i+1])
        );
    end

    assign m_axis_tdata = ODW'({m_ns, m_ts, m_ps, m_vid});
    assign m_axis_tuser = {m_status, m_new};

endmodule

/* sim/vertex_index_dedup_tb.sv */
// Self-checking testbench for vertex_index_dedup: directed table, then random groups of corners.
`timescale 1ns / 1ps

module vertex_index_dedup_tb;

    localparam int TABLE_DEPTH   = 256;
    localparam int REF_BITS      = 20;
    localparam int VERTEX_BITS   = 24;
    localparam int TOTAL_ITEMS   = 1400;
    localparam int FULL_GROUP    = 5;       // random group that is driven past the table depth
    localparam int PRESSURE_AT   = 40;
    localparam int PRESSURE_HOLD = 2000;
    localparam int CYCLE_LIMIT   = 1500000;

    typedef struct packed {
        logic [REF_BITS-1:0] normal;
        logic [REF_BITS-1:0] texture;
        logic [REF_BITS-1:0] position;
    } corner_t;

    // same bit order as {m_axis_tuser, m_axis_tdata}
    typedef struct packed {
        vidd_pkg::status_t      status;
        logic                   is_new;
        logic [REF_BITS-1:0]    normal_slot;
        logic [REF_BITS-1:0]    texture_slot;
        logic [REF_BITS-1:0]    position_slot;
        logic [VERTEX_BITS-1:0] vertex_index;
    } vertex_result_t;

    typedef struct packed {
        logic           func;
        corner_t        corner;
        logic           typed;
        vertex_result_t res;
    } stim_row_t;

    localparam vertex_result_t UNTYPED_RES = '0;
    localparam vertex_result_t ZERO_RES    = '{vidd_pkg::STAT_ZERO, 1'b0, 20'd0, 20'd0, 20'd0,
                                               24'd0};

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    vertex_index_dedup #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .REF_BITS    (REF_BITS),
        .VERTEX_BITS (VERTEX_BITS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Predictor state: seen table of the current group and the running counter
    corner_t                seen_keys [TABLE_DEPTH];
    logic [VERTEX_BITS-1:0] seen_ids  [TABLE_DEPTH];
    int unsigned            seen_fill   = 0;
    logic [VERTEX_BITS-1:0] next_vertex = '0;

    vertex_result_t vertex_results_due [$];
    int unsigned    fail_count    = 0;
    int unsigned    results_seen  = 0;
    int unsigned    corners_sent  = 0;
    int unsigned    groups_sent   = 0;
    int unsigned    new_count     = 0;
    int unsigned    reuse_count   = 0;
    int unsigned    zero_count    = 0;
    int unsigned    full_count    = 0;
    int unsigned    tx_burst      = 0;
    int unsigned    cycle_count   = 0;

    // Returns 1 when the item gives a result; group starts give none.
    function automatic bit dedup_predict(input logic func, input corner_t c,
                                         output vertex_result_t r);
        r = '0;
        if (func) begin
            seen_fill = 0;
            return 1'b0;
        end
        if (c.position == '0 || c.texture == '0 || c.normal == '0) begin
            r.status = vidd_pkg::STAT_ZERO;
            return 1'b1;
        end
        // a match wins over the full and saturated checks
        for (int i = 0; i < seen_fill; i++) begin
            if (seen_keys[i] == c) begin
                r.vertex_index = seen_ids[i];
                return 1'b1;
            end
        end
        if (seen_fill >= TABLE_DEPTH) begin
            r.status = vidd_pkg::STAT_FULL;
            return 1'b1;
        end
        if (next_vertex == '1) begin
            r.status = vidd_pkg::STAT_SATUR;
            return 1'b1;
        end
        seen_keys[seen_fill] = c;
        seen_ids[seen_fill]  = next_vertex;
        seen_fill++;
        r.is_new        = 1'b1;
        r.vertex_index  = next_vertex;
        r.position_slot = c.position - 1'b1;
        r.texture_slot  = c.texture - 1'b1;
        r.normal_slot   = c.normal - 1'b1;
        next_vertex++;
        return 1'b1;
    endfunction

    function automatic logic [REF_BITS-1:0] draw_ref();
        logic [REF_BITS-1:0] v;
        case ($urandom_range(0, 3))
            0: v = REF_BITS'($urandom_range(1, 16));
            1: v = 20'hFFFFF - REF_BITS'($urandom_range(0, 3));
            2: v = 20'd1 << $urandom_range(0, REF_BITS-1);
            default: v = REF_BITS'($urandom);
        endcase
        if (v == '0) v = 20'd1;
        return v;
    endfunction

    function automatic corner_t draw_corner();
        corner_t c;
        c.position = draw_ref();
        c.texture  = draw_ref();
        c.normal   = draw_ref();
        return c;
    endfunction

    // Offer one item after a random gap; predict once the transaction is taken.
    task automatic send_item(input logic func, input corner_t c, input logic typed,
                             input vertex_result_t typed_res);
        int unsigned    gap;
        vertex_result_t r;
        if (tx_burst != 0) begin
            tx_burst--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 9) == 0) tx_burst = $urandom_range(8, 32);
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {4'b0, c};
        do @(posedge aclk); while (!s_axis_tready);
        if (dedup_predict(func, c, r)) begin
            vertex_results_due.insert(vertex_results_due.size(), typed ? typed_res : r);
        end
        if (func) groups_sent++;
        else corners_sent++;
    endtask

    initial begin : stimulus
        stim_row_t   directed_rows [21];
        corner_t     pool [16];
        corner_t     c;
        int unsigned pool_n;
        int unsigned span;
        int unsigned pick;
        int unsigned group_no;
        logic [2:0]  mask;

        directed_rows = '{
            '{1'b0, {20'h00001, 20'h00001, 20'h00001}, 1'b1,
              '{vidd_pkg::STAT_OK, 1'b1, 20'd0, 20'd0, 20'd0, 24'd0}},
            '{1'b0, {20'h00001, 20'h00001, 20'h00001}, 1'b1,
              '{vidd_pkg::STAT_OK, 1'b0, 20'd0, 20'd0, 20'd0, 24'd0}},
            '{1'b0, {20'hFFFFF, 20'hFFFFF, 20'hFFFFF}, 1'b1,
              '{vidd_pkg::STAT_OK, 1'b1, 20'hFFFFE, 20'hFFFFE, 20'hFFFFE, 24'd1}},
            '{1'b0, {20'h00000, 20'h00000, 20'h00000}, 1'b1, ZERO_RES},
            '{1'b0, {20'h00007, 20'h00007, 20'h00000}, 1'b1, ZERO_RES},
            '{1'b0, {20'h00007, 20'h00000, 20'h00007}, 1'b1, ZERO_RES},
            '{1'b0, {20'h00000, 20'h00007, 20'h00007}, 1'b1, ZERO_RES},
            '{1'b0, {20'hFFFFF, 20'h00001, 20'hFFFFF}, 1'b0, UNTYPED_RES},
            '{1'b0, {20'h00001, 20'h00001, 20'h00001}, 1'b1,
              '{vidd_pkg::STAT_OK, 1'b0, 20'd0, 20'd0, 20'd0, 24'd0}},
            '{1'b1, {20'hFFFFF, 20'h55555, 20'hAAAAA}, 1'b0, UNTYPED_RES},
            // same triple in a fresh group must take a fresh index, not the stale one
            '{1'b0, {20'h00001, 20'h00001, 20'h00001}, 1'b1,
              '{vidd_pkg::STAT_OK, 1'b1, 20'd0, 20'd0, 20'd0, 24'd3}},
            '{1'b0, {20'hFFFFF, 20'hFFFFF, 20'hFFFFF}, 1'b0, UNTYPED_RES},
            '{1'b0, {20'h00001, 20'h00001, 20'h00001}, 1'b0, UNTYPED_RES},
            '{1'b0, {20'h00002, 20'h00001, 20'h00001}, 1'b0, UNTYPED_RES},
            '{1'b0, {20'h00001, 20'h00002, 20'h00001}, 1'b0, UNTYPED_RES},
            '{1'b0, {20'h00001, 20'h00001, 20'h00002}, 1'b0, UNTYPED_RES},
            '{1'b1, {20'h00000, 20'h00000, 20'h00000}, 1'b0, UNTYPED_RES},
            '{1'b1, {20'hFFFFF, 20'hFFFFF, 20'hFFFFF}, 1'b0, UNTYPED_RES},
            '{1'b0, {20'h12345, 20'h55555, 20'hAAAAA}, 1'b0, UNTYPED_RES},
            '{1'b0, {20'hFEDCB, 20'hAAAAA, 20'h55555}, 1'b0, UNTYPED_RES},
            '{1'b0, {20'h12345, 20'h55555, 20'hAAAAA}, 1'b0, UNTYPED_RES}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].func, directed_rows[i].corner,
                      directed_rows[i].typed, directed_rows[i].res);
        end

        // Counter saturation needs 2**24 fresh vertices and stays out of reach here.
        group_no = 0;
        while (corners_sent + groups_sent < TOTAL_ITEMS) begin
            send_item(1'b1, draw_corner(), 1'b0, UNTYPED_RES);
            if (group_no == FULL_GROUP) begin
                for (int k = 0; k < TABLE_DEPTH + 6; k++) begin
                    c = draw_corner();
                    if (k < 16) pool[k] = c;
                    send_item(1'b0, c, 1'b0, UNTYPED_RES);
                end
                // reuse still hits once full, zero refs still flagged first
                for (int k = 0; k < 6; k++) begin
                    send_item(1'b0, pool[$urandom_range(0, 15)], 1'b0, UNTYPED_RES);
                end
                send_item(1'b0, '0, 1'b0, UNTYPED_RES);
            end else begin
                pool_n = $urandom_range(1, 12);
                for (int k = 0; k < pool_n; k++) pool[k] = draw_corner();
                span = $urandom_range(1, 40);
                for (int k = 0; k < span; k++) begin
                    c    = pool[$urandom_range(0, pool_n - 1)];
                    pick = $urandom_range(0, 19);
                    if (pick == 0) begin
                        mask = 3'($urandom_range(1, 7));
                        if (mask[0]) c.position = '0;
                        if (mask[1]) c.texture  = '0;
                        if (mask[2]) c.normal   = '0;
                    end else if (pick == 1) begin
                        c = draw_corner();
                    end
                    // occasional group start in the middle of a group
                    send_item(pick == 2, c, 1'b0, UNTYPED_RES);
                end
            end
            group_no++;
        end
        s_axis_tvalid <= 1'b0;

        while (vertex_results_due.size() != 0) @(posedge aclk);
        repeat (TABLE_DEPTH + 8) @(posedge aclk);

        $display("Covered %0d corners in %0d group starts: %0d new, %0d reused,",
                 corners_sent, groups_sent, new_count, reuse_count);
        $display("%0d zero-ref and %0d table-full results, with a long receiver stall.",
                 zero_count, full_count);
        if (fail_count == 0) begin
            $display("PASS vertex_index_dedup");
        end else begin
            $display("FAIL vertex_index_dedup");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned    hold;
        int unsigned    rx_burst;
        vertex_result_t got;
        vertex_result_t want;
        rx_burst = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (results_seen == PRESSURE_AT) begin
                hold = PRESSURE_HOLD;
            end else if (rx_burst != 0) begin
                rx_burst--;
                hold = 0;
            end else begin
                hold = $urandom_range(0, 16);
                if ($urandom_range(0, 9) == 0) rx_burst = $urandom_range(8, 32);
            end
            if (hold != 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);

            got = {m_axis_tuser, m_axis_tdata[83:0]};
            results_seen++;
            if (got.status == vidd_pkg::STAT_ZERO) zero_count++;
            else if (got.status == vidd_pkg::STAT_FULL) full_count++;
            else if (got.is_new) new_count++;
            else reuse_count++;

            if (vertex_results_due.size() == 0) begin
                $error("result transaction with nothing expected: vertex_index %0h",
                       got.vertex_index);
                fail_count++;
            end else begin
                want = vertex_results_due.pop_front();
                if (got != want) begin
                    fail_count++;
                    if (got.vertex_index != want.vertex_index)
                        $error("vertex_index: expected %0h actual %0h",
                               want.vertex_index, got.vertex_index);
                    if (got.is_new != want.is_new)
                        $error("is_new: expected %0h actual %0h", want.is_new, got.is_new);
                    if (got.position_slot != want.position_slot)
                        $error("position_slot: expected %0h actual %0h",
                               want.position_slot, got.position_slot);
                    if (got.texture_slot != want.texture_slot)
                        $error("texture_slot: expected %0h actual %0h",
                               want.texture_slot, got.texture_slot);
                    if (got.normal_slot != want.normal_slot)
                        $error("normal_slot: expected %0h actual %0h",
                               want.normal_slot, got.normal_slot);
                    if (got.status != want.status)
                        $error("status: expected %0d actual %0d", want.status, got.status);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, vertex_results_due.size());
        $display("FAIL vertex_index_dedup");
        $finish;
    end

endmodule
